// File: rtl/fgrc_pkg.sv
// ----------------------------------------------------------------------------
// fgrc_pkg
// Shared types, codes and the size code decoder of the flash geometry checker.
// ----------------------------------------------------------------------------
`default_nettype none

package fgrc_pkg;

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_LOAD  = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_UNDECODE  = 4'd1;
  localparam logic [3:0] ST_WR_GT_ER  = 4'd2;
  localparam logic [3:0] ST_OVERLAP   = 4'd3;
  localparam logic [3:0] ST_OVER_4G   = 4'd4;
  localparam logic [3:0] ST_FULL      = 4'd5;
  localparam logic [3:0] ST_INVALID   = 4'd6;
  localparam logic [3:0] ST_BAD_START = 4'd7;
  localparam logic [3:0] ST_END_OUT   = 4'd8;
  localparam logic [3:0] ST_END_EDGE  = 4'd9;

  localparam logic [49:0] FOUR_GIB = 50'h1_0000_0000;

  // one stored region, sizes already decoded
  typedef struct packed {
    logic [31:0] base;
    logic [31:0] esize;
    logic [31:0] wsize;
    logic [32:0] ext_e;
    logic [32:0] ext_w;
  } region_t;

  typedef struct packed {
    logic        start;
    logic [32:0] dividend;
    logic [31:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] remainder;
  } mod_rsp_t;

  // {valid, size}: 2^c below 32, else m*2^k with m 5..7 and k below 30
  function automatic logic [32:0] size_decode(input logic [7:0] code);
    logic [32:0] r;
    r = '0;
    if (code < 8'd32) begin
      r = {1'b1, 32'd1 << code[4:0]};
    end else if (code[7:5] > 3'd4 && code[4:0] < 5'd30) begin
      r = {1'b1, {29'd0, code[7:5]} << code[4:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/flash_geometry_range_checker_unit.sv
// ----------------------------------------------------------------------------
// flash_geometry_range_checker_unit
// Region table with load checks and block-walk range queries.
// ----------------------------------------------------------------------------
// Timing: a load runs the remainder unit and a table scan; a query scans the
// table and runs the remainder unit for each region crossed.
// Throughput: one beat at a time; a new beat is taken only once the result
// beat has been accepted.
// Reset: table empty, invalid flag clear; table contents undefined, no sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module flash_geometry_range_checker_unit #(
  parameter int MAX_REGIONS = 64
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // region_base[31:0] erase_code[39:32] write_code[47:40] block_count[63:48]
  // range_start[95:64] range_len[127:96] for_write[128], zero pad
  input  wire [135:0]  s_axis_tdata,
  // req_type[1:0]
  input  wire [1:0]    s_axis_tuser,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // status[3:0] range_ok[4] suggested_len[37:5], zero pad
  output logic [39:0]  m_axis_tdata
);

  localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CW = $clog2(MAX_REGIONS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_REGIONS);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_LMUL  = 4'd2;
  localparam logic [3:0] S_LTOT  = 4'd3;
  localparam logic [3:0] S_LMOD  = 4'd4;
  localparam logic [3:0] S_LMUL2 = 4'd5;
  localparam logic [3:0] S_LRD   = 4'd6;
  localparam logic [3:0] S_LCMP  = 4'd7;
  localparam logic [3:0] S_LWR   = 4'd8;
  localparam logic [3:0] S_QRD   = 4'd9;
  localparam logic [3:0] S_QCMP  = 4'd10;
  localparam logic [3:0] S_QMOD  = 4'd11;
  localparam logic [3:0] S_QSTEP = 4'd12;
  localparam logic [3:0] S_QRND  = 4'd13;
  localparam logic [3:0] S_QCHK  = 4'd14;
  localparam logic [3:0] S_OUT   = 4'd15;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] total_q, total_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [32:0]   bytes_q, bytes_d;
  logic          inv_q, inv_d;
  logic          first_q, first_d;

  logic [1:0]    req_q, req_d;
  logic [31:0]   base_q, base_d;
  logic [7:0]    ecode_q, ecode_d;
  logic [7:0]    wcode_q, wcode_d;
  logic [16:0]   cnt_q, cnt_d;
  logic [31:0]   start_q, start_d;
  logic [31:0]   len_q, len_d;
  logic          fw_q, fw_d;
  logic [31:0]   es_q, es_d;
  logic [31:0]   ws_q, ws_d;
  logic [31:0]   mulb_q, mulb_d;
  logic [48:0]   prod_q, prod_d;
  logic [32:0]   ee_q, ee_d;
  logic [32:0]   acc_q, acc_d;
  logic [31:0]   bs_q, bs_d;
  logic [32:0]   rem_q, rem_d;
  logic [3:0]    st_q, st_d;
  logic          ok_q, ok_d;
  logic [32:0]   sugg_q, sugg_d;

  fgrc_pkg::mod_req_t mod_req;
  fgrc_pkg::mod_rsp_t mod_rsp;
  fgrc_pkg::region_t  rd_data;
  fgrc_pkg::region_t  wr_data;
  logic               mem_we;
  logic [IW-1:0]      rd_addr;

  logic [32:0] dec_e, dec_w;
  logic [32:0] addr, off, ext, need;
  logic [31:0] sel_bs;
  logic [49:0] sum_tot, sum_end;
  logic [CW-1:0] idx_inc;

  fgrc_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  fgrc_region_mem #(.DEPTH(MAX_REGIONS), .AW(IW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (total_q[IW-1:0]),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign dec_e   = fgrc_pkg::size_decode(ecode_q);
  assign dec_w   = fgrc_pkg::size_decode(wcode_q);
  assign addr    = {1'b0, start_q} + acc_q;
  assign off     = addr - {1'b0, rd_data.base};
  assign ext     = fw_q ? rd_data.ext_w : rd_data.ext_e;
  assign sel_bs  = fw_q ? rd_data.wsize : rd_data.esize;
  assign need    = {1'b0, len_q} - acc_q;
  assign sum_tot = 50'(bytes_q) + 50'(prod_q);
  assign sum_end = 50'(base_q) + 50'(prod_q);
  assign idx_inc = idx_q + CW'(1);
  assign rd_addr = idx_q[IW-1:0];
  assign wr_data = '{base: base_q, esize: es_q, wsize: ws_q, ext_e: ee_q,
                     ext_w: prod_q[32:0]};

  always_comb begin
    state_d = state_q;
    total_d = total_q;
    idx_d   = idx_q;
    bytes_d = bytes_q;
    inv_d   = inv_q;
    first_d = first_q;
    req_d   = req_q;
    base_d  = base_q;
    ecode_d = ecode_q;
    wcode_d = wcode_q;
    cnt_d   = cnt_q;
    start_d = start_q;
    len_d   = len_q;
    fw_d    = fw_q;
    es_d    = es_q;
    ws_d    = ws_q;
    mulb_d  = mulb_q;
    prod_d  = prod_q;
    ee_d    = ee_q;
    acc_d   = acc_q;
    bs_d    = bs_q;
    rem_d   = rem_q;
    st_d    = st_q;
    ok_d    = ok_q;
    sugg_d  = sugg_q;
    mem_we  = 1'b0;
    mod_req = '0;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          req_d   = s_axis_tuser;
          base_d  = s_axis_tdata[31:0];
          ecode_d = s_axis_tdata[39:32];
          wcode_d = s_axis_tdata[47:40];
          cnt_d   = (s_axis_tdata[63:48] == 16'd0) ? 17'h10000 : {1'b0, s_axis_tdata[63:48]};
          start_d = s_axis_tdata[95:64];
          len_d   = s_axis_tdata[127:96];
          fw_d    = s_axis_tdata[128];
          st_d    = fgrc_pkg::ST_OK;
          ok_d    = 1'b0;
          sugg_d  = '0;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        state_d = S_OUT;
        unique case (req_q)
          fgrc_pkg::REQ_CLEAR: begin
            total_d = '0;
            bytes_d = '0;
            inv_d   = 1'b0;
          end
          fgrc_pkg::REQ_LOAD: begin
            es_d = dec_e[31:0];
            ws_d = dec_w[31:0];
            if (inv_q) begin
              st_d = fgrc_pkg::ST_INVALID;
            end else if (!dec_w[32] || !dec_e[32]) begin
              st_d  = fgrc_pkg::ST_UNDECODE;
              inv_d = 1'b1;
            end else if (dec_w[31:0] > dec_e[31:0]) begin
              st_d  = fgrc_pkg::ST_WR_GT_ER;
              inv_d = 1'b1;
            end else if (total_q >= MAX_CNT) begin
              st_d  = fgrc_pkg::ST_FULL;
              inv_d = 1'b1;
            end else begin
              state_d = S_LMUL;
            end
          end
          fgrc_pkg::REQ_QUERY: begin
            if (len_q == 32'd0) begin
              ok_d = 1'b1;
            end else if (inv_q || total_q == '0) begin
              st_d = fgrc_pkg::ST_INVALID;
            end else begin
              acc_d   = '0;
              idx_d   = '0;
              first_d = 1'b1;
              state_d = S_QRD;
            end
          end
          default: begin
          end
        endcase
      end
      S_LMUL: begin
        prod_d  = 49'(cnt_q) * 49'(es_q);
        state_d = S_LTOT;
      end
      S_LTOT: begin
        if (sum_tot > fgrc_pkg::FOUR_GIB || sum_end > fgrc_pkg::FOUR_GIB) begin
          st_d    = fgrc_pkg::ST_OVER_4G;
          inv_d   = 1'b1;
          state_d = S_OUT;
        end else begin
          ee_d             = prod_q[32:0];
          mod_req.start    = 1'b1;
          mod_req.dividend = {1'b0, es_q};
          mod_req.divisor  = ws_q;
          state_d          = S_LMOD;
        end
      end
      S_LMOD: begin
        if (mod_rsp.done) begin
          mulb_d  = es_q - mod_rsp.remainder;
          state_d = S_LMUL2;
        end
      end
      S_LMUL2: begin
        // write extent: count * (erase - erase mod write)
        prod_d  = 49'(cnt_q) * 49'(mulb_q);
        idx_d   = '0;
        state_d = (total_q == '0) ? S_LWR : S_LRD;
      end
      S_LRD: begin
        state_d = S_LCMP;
      end
      S_LCMP: begin
        if ({1'b0, base_q} < ({1'b0, rd_data.base} + rd_data.ext_e) &&
            {1'b0, rd_data.base} < ({1'b0, base_q} + ee_q)) begin
          st_d    = fgrc_pkg::ST_OVERLAP;
          inv_d   = 1'b1;
          state_d = S_OUT;
        end else begin
          idx_d   = idx_inc;
          state_d = (idx_inc == total_q) ? S_LWR : S_LRD;
        end
      end
      S_LWR: begin
        mem_we  = 1'b1;
        total_d = total_q + CW'(1);
        bytes_d = bytes_q + ee_q;
        state_d = S_OUT;
      end
      S_QRD: begin
        state_d = S_QCMP;
      end
      S_QCMP: begin
        if (addr >= {1'b0, rd_data.base} && off < ext) begin
          bs_d             = sel_bs;
          rem_d            = ext - off;
          mod_req.start    = 1'b1;
          mod_req.dividend = off;
          mod_req.divisor  = sel_bs;
          state_d          = S_QMOD;
        end else begin
          idx_d = idx_inc;
          if (idx_inc == total_q) begin
            st_d    = first_q ? fgrc_pkg::ST_BAD_START : fgrc_pkg::ST_END_OUT;
            state_d = S_OUT;
          end else begin
            state_d = S_QRD;
          end
        end
      end
      S_QMOD: begin
        // regions never overlap, so a misaligned hit means no block starts here
        if (mod_rsp.done) begin
          if (mod_rsp.remainder == 32'd0) begin
            state_d = S_QSTEP;
          end else begin
            st_d    = first_q ? fgrc_pkg::ST_BAD_START : fgrc_pkg::ST_END_OUT;
            state_d = S_OUT;
          end
        end
      end
      S_QSTEP: begin
        first_d = 1'b0;
        if (need >= rem_q) begin
          acc_d   = acc_q + rem_q;
          state_d = S_QCHK;
        end else begin
          mod_req.start    = 1'b1;
          mod_req.dividend = need;
          mod_req.divisor  = bs_q;
          state_d          = S_QRND;
        end
      end
      S_QRND: begin
        if (mod_rsp.done) begin
          if (mod_rsp.remainder == 32'd0) begin
            acc_d = acc_q + need;
          end else begin
            acc_d = acc_q + need + {1'b0, bs_q - mod_rsp.remainder};
          end
          state_d = S_QCHK;
        end
      end
      S_QCHK: begin
        if (acc_q < {1'b0, len_q}) begin
          idx_d   = '0;
          state_d = S_QRD;
        end else if (acc_q == {1'b0, len_q}) begin
          ok_d    = 1'b1;
          state_d = S_OUT;
        end else begin
          st_d    = fgrc_pkg::ST_END_EDGE;
          sugg_d  = acc_q;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (m_axis_tready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      total_q <= '0;
      idx_q   <= '0;
      bytes_q <= '0;
      inv_q   <= 1'b0;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      idx_q   <= idx_d;
      bytes_q <= bytes_d;
      inv_q   <= inv_d;
      first_q <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    base_q  <= base_d;
    ecode_q <= ecode_d;
    wcode_q <= wcode_d;
    cnt_q   <= cnt_d;
    start_q <= start_d;
    len_q   <= len_d;
    fw_q    <= fw_d;
    es_q    <= es_d;
    ws_q    <= ws_d;
    mulb_q  <= mulb_d;
    prod_q  <= prod_d;
    ee_q    <= ee_d;
    acc_q   <= acc_d;
    bs_q    <= bs_d;
    rem_q   <= rem_d;
    st_q    <= st_d;
    ok_q    <= ok_d;
    sugg_q  <= sugg_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {2'b00, sugg_q, ok_q, st_q};

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("input and output open at once");
  a_total_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= MAX_CNT) else $error("region count above table depth");
  a_sugg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && st_q != fgrc_pkg::ST_END_EDGE) |-> sugg_q == '0)
    else $error("suggested length without edge miss");
  a_ok_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && ok_q) |-> st_q == fgrc_pkg::ST_OK)
    else $error("range ok with error status");

endmodule

`default_nettype wire

// File: rtl/fgrc_mod_unit.sv
// ----------------------------------------------------------------------------
// fgrc_mod_unit
// Restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fgrc_mod_unit (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  fgrc_pkg::mod_req_t  req_i,
  output fgrc_pkg::mod_rsp_t  rsp_o
);

  logic [32:0] num_q, num_d;
  logic [31:0] div_q, div_d;
  logic [31:0] rem_q, rem_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        done_q, done_d;
  logic [32:0] trial;

  always_comb begin
    num_d  = num_q;
    div_d  = div_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    trial  = {rem_q, num_q[32]};
    if (req_i.start) begin
      num_d = req_i.dividend;
      div_d = req_i.divisor;
      rem_d = '0;
      cnt_d = 6'd33;
    end else if (cnt_q != 6'd0) begin
      num_d = {num_q[31:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        rem_d = 32'(trial - {1'b0, div_q});
      end else begin
        rem_d = trial[31:0];
      end
      cnt_d = cnt_q - 6'd1;
      done_d = (cnt_q == 6'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.remainder = rem_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q > 6'd1) |-> !req_i.start) else $error("mod unit restarted while busy");
  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 6'd1 && !req_i.start) |=> done_q) else $error("mod done missing");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> cnt_q == 6'd0) else $error("mod done while busy");

endmodule

`default_nettype wire

// File: rtl/fgrc_region_mem.sv
// ----------------------------------------------------------------------------
// fgrc_region_mem
// Region descriptor table, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module fgrc_region_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire                 clk_i,
  input  wire                 we_i,
  input  wire [AW-1:0]        waddr_i,
  input  fgrc_pkg::region_t   wdata_i,
  input  wire [AW-1:0]        raddr_i,
  output fgrc_pkg::region_t   rdata_o
);

  fgrc_pkg::region_t mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// File: dv/tb_flash_geometry_range_checker_unit.sv
// ----------------------------------------------------------------------------
// tb_flash_geometry_range_checker_unit
// Self-checking bench for the flash region table. A directed table covers
// clear, every load rejection but a full table and the query corner cases.
// Random load/query sessions and raw noise beats follow. Every result beat
// is compared field by field against the directed table's expected result
// or an in-bench geometry predictor. Both stream sides stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_flash_geometry_range_checker_unit;

  localparam int          TBL_DEPTH = 64;
  localparam int          N_ITEMS   = 2000;
  localparam int          WD_LIMIT  = 200000;
  localparam logic [1:0]  REQ_NONE  = 2'd3;
  localparam longint unsigned SPAN_4G = 64'h1_0000_0000;

  typedef struct {
    logic [1:0]  req;
    logic [31:0] base;
    logic [7:0]  ecode;
    logic [7:0]  wcode;
    logic [15:0] cnt;
    logic [31:0] start;
    logic [31:0] len;
    logic        wr;
  } req_t;

  typedef struct {
    logic [3:0]  status;
    logic        ok;
    logic [32:0] sugg;
  } rsp_t;

  typedef struct {
    req_t rq;
    bit   typed;
    rsp_t rs;
  } dir_row_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [39:0]  m_axis_tdata;

  flash_geometry_range_checker_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // predictor copy of the region table
  logic [31:0]     rg_base [TBL_DEPTH];
  logic [7:0]      rg_ecode[TBL_DEPTH];
  logic [7:0]      rg_wcode[TBL_DEPTH];
  longint unsigned rg_cnt  [TBL_DEPTH];
  int              rg_total;
  longint unsigned rg_bytes;
  bit              rg_bad;

  rsp_t rsp_pending[$];
  int   n_fail;
  int   n_sent;
  int   n_seen;
  int   st_hist[16];
  bit   calm;
  int   quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor
  function automatic bit size_of(input logic [7:0] c, output longint unsigned sz);
    sz = 1;
    if (c < 8'd32) begin
      sz = longint'(1) << c;
      return 1'b1;
    end
    if (c[7:5] > 3'd4 && c[4:0] < 5'd30) begin
      sz = longint'(c[7:5]) << c[4:0];
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void region_shape(input int r, input bit wr,
                                       output longint unsigned bs,
                                       output longint unsigned nb,
                                       output longint unsigned ext);
    longint unsigned es, ws;
    bit d;
    d = size_of(rg_ecode[r], es);
    d = size_of(rg_wcode[r], ws);
    if (ws == 0) ws = 1;
    bs  = wr ? ws : es;
    nb  = wr ? rg_cnt[r] * (es / ws) : rg_cnt[r];
    ext = rg_cnt[r] * es;
  endfunction

  function automatic bit block_at(input longint unsigned addr, input bit wr,
                                  output longint unsigned bs,
                                  output longint unsigned left);
    longint unsigned s, n, e, off;
    bs = 0;
    left = 0;
    for (int r = 0; r < rg_total; r++) begin
      region_shape(r, wr, s, n, e);
      if (addr < rg_base[r]) continue;
      off = addr - rg_base[r];
      if (off >= s * n || off % s != 0) continue;
      bs = s;
      left = n - off / s;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [3:0] table_load(input req_t q);
    longint unsigned es, ws, ext, cnt, s, n, e;
    if (rg_bad) return fgrc_pkg::ST_INVALID;
    if (!size_of(q.wcode, ws) || !size_of(q.ecode, es)) begin
      rg_bad = 1'b1;
      return fgrc_pkg::ST_UNDECODE;
    end
    if (ws > es) begin
      rg_bad = 1'b1;
      return fgrc_pkg::ST_WR_GT_ER;
    end
    if (rg_total >= TBL_DEPTH) begin
      rg_bad = 1'b1;
      return fgrc_pkg::ST_FULL;
    end
    cnt = (q.cnt == 0) ? 64'h10000 : q.cnt;
    ext = cnt * es;
    if (rg_bytes + ext > SPAN_4G || longint'(q.base) + ext > SPAN_4G) begin
      rg_bad = 1'b1;
      return fgrc_pkg::ST_OVER_4G;
    end
    for (int r = 0; r < rg_total; r++) begin
      region_shape(r, 1'b0, s, n, e);
      if (longint'(q.base) < rg_base[r] + e && rg_base[r] < longint'(q.base) + ext) begin
        rg_bad = 1'b1;
        return fgrc_pkg::ST_OVERLAP;
      end
    end
    rg_base[rg_total]  = q.base;
    rg_ecode[rg_total] = q.ecode;
    rg_wcode[rg_total] = q.wcode;
    rg_cnt[rg_total]   = cnt;
    rg_total++;
    rg_bytes += ext;
    return fgrc_pkg::ST_OK;
  endfunction

  function automatic rsp_t range_walk(input req_t q);
    rsp_t o;
    longint unsigned acc, bs, left, need, k;
    o = '{fgrc_pkg::ST_OK, 1'b0, '0};
    acc = 0;
    if (q.len == 0) begin
      o.ok = 1'b1;
      return o;
    end
    if (rg_bad || rg_total == 0) begin
      o.status = fgrc_pkg::ST_INVALID;
      return o;
    end
    if (!block_at(q.start, q.wr, bs, left)) begin
      o.status = fgrc_pkg::ST_BAD_START;
      return o;
    end
    while (acc < q.len) begin
      if (!block_at(longint'(q.start) + acc, q.wr, bs, left)) begin
        o.status = fgrc_pkg::ST_END_OUT;
        return o;
      end
      need = q.len - acc;
      k = (need + bs - 1) / bs;
      if (k > left) k = left;
      acc += k * bs;
    end
    if (acc == q.len) begin
      o.ok = 1'b1;
      return o;
    end
    o.status = fgrc_pkg::ST_END_EDGE;
    o.sugg = acc[32:0];
    return o;
  endfunction

  function automatic rsp_t geometry_predict(input req_t q);
    rsp_t o;
    o = '{fgrc_pkg::ST_OK, 1'b0, '0};
    case (q.req)
      fgrc_pkg::REQ_CLEAR: begin
        rg_total = 0;
        rg_bytes = 0;
        rg_bad = 1'b0;
      end
      fgrc_pkg::REQ_LOAD:  o.status = table_load(q);
      fgrc_pkg::REQ_QUERY: o = range_walk(q);
      default: ;
    endcase
    return o;
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic req_t blank_req(input logic [1:0] req);
    req_t q;
    q = '{req, '0, '0, '0, '0, '0, '0, 1'b0};
    return q;
  endfunction

  function automatic req_t load_req(input logic [31:0] base, input logic [7:0] ec,
                                    input logic [7:0] wc, input logic [15:0] cnt);
    req_t q;
    q = blank_req(fgrc_pkg::REQ_LOAD);
    q.base = base;
    q.ecode = ec;
    q.wcode = wc;
    q.cnt = cnt;
    return q;
  endfunction

  function automatic req_t query_req(input logic [31:0] start, input logic [31:0] len,
                                     input logic wr);
    req_t q;
    q = blank_req(fgrc_pkg::REQ_QUERY);
    q.start = start;
    q.len = len;
    q.wr = wr;
    return q;
  endfunction

  task automatic send_beat(input req_t q, input bit typed, input rsp_t typed_rsp);
    rsp_t p;
    if (!calm && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 16)) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
      end
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= q.req;
    s_axis_tdata  <= {7'd0, q.wr, q.len, q.start, q.cnt, q.wcode, q.ecode, q.base};
    do @(posedge clk_i); while (!s_axis_tready);
    p = geometry_predict(q);
    rsp_pending.push_back(typed ? typed_rsp : p);
    n_sent++;
  endtask

  function automatic logic [7:0] pick_code();
    if ($urandom_range(0, 2) == 0)
      return {3'($urandom_range(5, 7)), 5'($urandom_range(0, 10))};
    return 8'($urandom_range(0, 12));
  endfunction

  task automatic random_load(inout longint unsigned next_addr);
    logic [7:0] ec, wc;
    longint unsigned es, ws;
    logic [15:0] cnt;
    bit d;
    ec = pick_code();
    do wc = pick_code(); while (size_of(wc, ws) && size_of(ec, es) && ws > es &&
                                $urandom_range(0, 9) != 0);
    cnt = ($urandom_range(0, 20) == 0) ? 16'd0 : 16'($urandom_range(1, 8));
    d = size_of(ec, es);
    if ($urandom_range(0, 3) == 0) next_addr += $urandom_range(1, 4096);
    if ($urandom_range(0, 15) == 0) next_addr = $urandom;  // may overlap or wrap
    send_beat(load_req(next_addr[31:0], ec, wc, cnt), 1'b0,
              '{fgrc_pkg::ST_OK, 1'b0, '0});
    next_addr += (cnt == 0 ? 64'h10000 : longint'(cnt)) * es;
  endtask

  task automatic random_query();
    int r;
    bit wr;
    longint unsigned bs, nb, ext, idx, k, start, len;
    if (rg_total == 0) begin
      send_beat(query_req($urandom, $urandom_range(0, 64), $urandom_range(0, 1)),
                1'b0, '{fgrc_pkg::ST_OK, 1'b0, '0});
      return;
    end
    r = $urandom_range(0, rg_total - 1);
    wr = $urandom_range(0, 1);
    region_shape(r, wr, bs, nb, ext);
    if (nb == 0) begin
      bs = 1;
      nb = 1;
    end
    idx = $urandom_range(0, nb - 1);
    start = rg_base[r] + idx * bs;
    k = $urandom_range(1, 2 * (nb - idx) + 2);
    len = k * bs;
    case ($urandom_range(0, 5))
      0: len -= $urandom_range(0, bs - 1);
      1: start += $urandom_range(1, 3);
      2: len = $urandom;
      default: ;
    endcase
    send_beat(query_req(start[31:0], len[31:0], wr), 1'b0,
              '{fgrc_pkg::ST_OK, 1'b0, '0});
  endtask

  // ---------------------------------------------------------------- sink side
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 16) - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      rsp_t got, want;
      got.status = m_axis_tdata[3:0];
      got.ok     = m_axis_tdata[4];
      got.sugg   = m_axis_tdata[37:5];
      n_seen++;
      if (rsp_pending.size() == 0) begin
        $display("%0t: unexpected result beat status=%0d ok=%0b sugg=%0h",
                 $realtime, got.status, got.ok, got.sugg);
        n_fail++;
      end else begin
        want = rsp_pending.pop_front();
        st_hist[got.status]++;
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $realtime, want.status, got.status);
          n_fail++;
        end
        if (got.ok !== want.ok) begin
          $display("%0t: range_ok expected %0b actual %0b", $realtime, want.ok, got.ok);
          n_fail++;
        end
        if (got.sugg !== want.sugg) begin
          $display("%0t: suggested_len expected %0h actual %0h",
                   $realtime, want.sugg, got.sugg);
          n_fail++;
        end
      end
    end
  end

  // watchdog: cycles with no beat on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WD_LIMIT) begin
      $display("%0t: watchdog expired", $realtime);
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- main flow
  initial begin
    dir_row_t        dir[$];
    longint unsigned next_addr;
    int              n_load;
    rsp_t            none;
    req_t            junk;
    none = '{fgrc_pkg::ST_OK, 1'b0, '0};
    n_fail = 0;
    n_sent = 0;
    n_seen = 0;
    calm = 1'b0;
    quiet_cycles = 0;
    rg_total = 0;
    rg_bytes = 0;
    rg_bad = 1'b0;
    foreach (st_hist[i]) st_hist[i] = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = fgrc_pkg::REQ_CLEAR;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    dir.push_back('{query_req(32'hFFFF_FFFF, 32'd0, 1'b1), 1'b1,
                    '{fgrc_pkg::ST_OK, 1'b1, '0}});
    dir.push_back('{query_req(32'd0, 32'hFFFF_FFFF, 1'b0), 1'b1,
                    '{fgrc_pkg::ST_INVALID, 1'b0, '0}});
    dir.push_back('{blank_req(REQ_NONE), 1'b1, none});
    dir.push_back('{load_req(32'd0, 8'hFF, 8'd0, 16'd1), 1'b1,
                    '{fgrc_pkg::ST_UNDECODE, 1'b0, '0}});
    dir.push_back('{load_req(32'd0, 8'd12, 8'd9, 16'd1), 1'b1,
                    '{fgrc_pkg::ST_INVALID, 1'b0, '0}});
    dir.push_back('{query_req(32'd0, 32'd4096, 1'b0), 1'b1,
                    '{fgrc_pkg::ST_INVALID, 1'b0, '0}});
    dir.push_back('{blank_req(fgrc_pkg::REQ_CLEAR), 1'b1, none});
    dir.push_back('{load_req(32'd0, 8'd10, 8'd12, 16'd1), 1'b1,
                    '{fgrc_pkg::ST_WR_GT_ER, 1'b0, '0}});
    dir.push_back('{blank_req(fgrc_pkg::REQ_CLEAR), 1'b1, none});
    dir.push_back('{load_req(32'd0, 8'd31, 8'd0, 16'd0), 1'b1,
                    '{fgrc_pkg::ST_OVER_4G, 1'b0, '0}});
    dir.push_back('{blank_req(fgrc_pkg::REQ_CLEAR), 1'b1, none});
    dir.push_back('{load_req(32'hFFFF_F000, 8'd12, 8'd9, 16'd1), 1'b1, none});
    dir.push_back('{load_req(32'd0, 8'd12, 8'd9, 16'd16), 1'b1, none});
    dir.push_back('{load_req(32'h0001_0000, 8'hA3, 8'd3, 16'd0), 1'b1, none});
    dir.push_back('{query_req(32'hFFFF_F000, 32'd4096, 1'b0), 1'b1,
                    '{fgrc_pkg::ST_OK, 1'b1, '0}});
    dir.push_back('{query_req(32'd0, 32'd65536, 1'b1), 1'b1,
                    '{fgrc_pkg::ST_OK, 1'b1, '0}});
    dir.push_back('{query_req(32'd1, 32'd8, 1'b0), 1'b1,
                    '{fgrc_pkg::ST_BAD_START, 1'b0, '0}});
    dir.push_back('{query_req(32'd0, 32'd100, 1'b0), 1'b0, none});
    dir.push_back('{query_req(32'd0, 32'h0001_0001, 1'b0), 1'b0, none});
    dir.push_back('{query_req(32'h0001_0000, 32'd100, 1'b1), 1'b0, none});
    dir.push_back('{query_req(32'h0001_0000, 32'd41, 1'b0), 1'b0, none});
    dir.push_back('{query_req(32'hFFFF_F000, 32'hFFFF_FFFF, 1'b0), 1'b0, none});
    dir.push_back('{load_req(32'h0000_1000, 8'd12, 8'd12, 16'd1), 1'b1,
                    '{fgrc_pkg::ST_OVERLAP, 1'b0, '0}});
    dir.push_back('{blank_req(fgrc_pkg::REQ_CLEAR), 1'b1, none});
    foreach (dir[i]) send_beat(dir[i].rq, dir[i].typed, dir[i].rs);

    while (n_sent < N_ITEMS) begin
      if (n_sent > N_ITEMS * 17 / 20) calm = 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        junk = '{2'($urandom), $urandom, 8'($urandom), 8'($urandom), 16'($urandom),
                 $urandom, $urandom, 1'($urandom)};
        send_beat(junk, 1'b0, none);
      end else begin
        send_beat(blank_req(fgrc_pkg::REQ_CLEAR), 1'b0, none);
        next_addr = $urandom & 32'hFFF0_0000;
        // now and then fill the table past its depth
        n_load = ($urandom_range(0, 19) == 0) ? TBL_DEPTH + 1 : $urandom_range(1, 6);
        repeat (n_load) random_load(next_addr);
        repeat ($urandom_range(4, 12)) random_query();
      end
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    while (rsp_pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("%0d beats sent, %0d results checked; ok=%0d bad_start=%0d end_out=%0d",
             n_sent, n_seen, st_hist[fgrc_pkg::ST_OK], st_hist[fgrc_pkg::ST_BAD_START],
             st_hist[fgrc_pkg::ST_END_OUT]);
    $display("edge_miss=%0d undecodable=%0d overlap=%0d over4g=%0d full=%0d invalid=%0d",
             st_hist[fgrc_pkg::ST_END_EDGE], st_hist[fgrc_pkg::ST_UNDECODE],
             st_hist[fgrc_pkg::ST_OVERLAP], st_hist[fgrc_pkg::ST_OVER_4G],
             st_hist[fgrc_pkg::ST_FULL], st_hist[fgrc_pkg::ST_INVALID]);
    if (n_fail == 0 && rsp_pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
rtl/fgrc_pkg.sv
rtl/fgrc_mod_unit.sv
rtl/fgrc_region_mem.sv
rtl/flash_geometry_range_checker_unit.sv
dv/tb_flash_geometry_range_checker_unit.sv
